// File: hdl/bfa_pkg.sv
package bfa_pkg;

	localparam int NUM_FRAMES_DEF  = 32768;
	localparam int FRAME_BYTES_DEF = 4096;

	localparam int ADDR_W = 27;
	localparam int CNT_W  = 16;
	localparam int BASE_W = 32;
	localparam int REQ_W  = 2;

	localparam logic [CNT_W-1:0] TOTAL_RST = 16'd32768;

	localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RESERVE = 2'd2;

	typedef struct packed {
		logic fill_init;  // restart the fill pointer
		logic fill_wr;    // write all ones at pointer, advance
		logic load;       // capture request
		logic rd_cur;     // read word at pointer
		logic rd_nxt;     // read word after pointer, advance
		logic alloc_wr;   // write back hit word, count up
		logic prep;       // set up region word bounds
		logic rgn_wr;     // write masked word at pointer
		logic rd_zero;    // read word 0
		logic zero_wr;    // force frame 0 used, region count update
		logic rsp_load;   // fill output register
	} bfa_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic is_alloc;
		logic is_region;
		logic alloc_go;
		logic word_free;
		logic scan_last;
		logic rgn_nonempty;
		logic rgn_last;
	} bfa_sts_t;

endpackage

// File: hdl/bfa_req_if.sv
interface bfa_req_if;
	logic                            valid;
	logic                            ready;
	logic [bfa_pkg::REQ_W-1:0]       req_type;
	logic [bfa_pkg::BASE_W-1:0]      region_base;
	logic [bfa_pkg::BASE_W-1:0]      region_size;

	modport source(output valid, output req_type, output region_base, output region_size,
		input ready);
	modport sink(input valid, input req_type, input region_base, input region_size,
		output ready);
endinterface

// File: hdl/bfa_rsp_if.sv
interface bfa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bfa_pkg::ADDR_W-1:0]  frame_address;
	logic                        success;
	logic [bfa_pkg::CNT_W-1:0]   frames_in_use;

	modport source(output valid, output frame_address, output success, output frames_in_use,
		input ready);
	modport sink(input valid, input frame_address, input success, input frames_in_use,
		output ready);
endinterface

// File: hdl/bitmap_frame_allocator.sv
// Allocate: scans from word 0, one word per cycle through the bitmap memory read port,
//   to the first word with a clear bit; a refused one scans none. Result is registered.
// Release/reserve: rewrite each word the region covers (none if empty), then word 0.
// One request in flight; the next is taken while the previous result waits at the output.
// Reset and every total_frames write run a fill, one word per cycle,
//   setting every frame used; no request is taken until it ends.
module bitmap_frame_allocator #(
	parameter int NUM_FRAMES  = bfa_pkg::NUM_FRAMES_DEF,
	parameter int FRAME_BYTES = bfa_pkg::FRAME_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [bfa_pkg::CNT_W-1:0]  cfg_wr_data,
	bfa_req_if.sink                    req,
	bfa_rsp_if.source                  rsp
);

	bfa_pkg::bfa_cmd_t cmd;
	bfa_pkg::bfa_sts_t sts;

	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bfa_datapath #(
		.NUM_FRAMES  (NUM_FRAMES),
		.FRAME_BYTES (FRAME_BYTES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req.req_type),
		.region_base   (req.region_base),
		.region_size   (req.region_size),
		.frame_address (rsp.frame_address),
		.success       (rsp.success),
		.frames_in_use (rsp.frames_in_use)
	);

endmodule

// File: hdl/bfa_ctrl.sv
module bfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  bfa_pkg::bfa_sts_t sts,
	output bfa_pkg::bfa_cmd_t cmd
);

	typedef enum logic [9:0] {
		S_FILL  = 10'b00_0000_0001,
		S_IDLE  = 10'b00_0000_0010,
		S_DISP  = 10'b00_0000_0100,
		S_A_CHK = 10'b00_0000_1000,
		S_PREP  = 10'b00_0001_0000,
		S_R_RD  = 10'b00_0010_0000,
		S_R_WR  = 10'b00_0100_0000,
		S_Z_RD  = 10'b00_1000_0000,
		S_Z_WR  = 10'b01_0000_0000,
		S_FIN   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;

	assign req_ready = (state_q == S_IDLE) && !cfg_wr_en;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_FILL: begin
				cmd.fill_wr = 1'b1;
				if (sts.fill_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid && req_ready) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.is_alloc) begin
					if (sts.alloc_go) begin
						cmd.rd_cur = 1'b1;
						state_d    = S_A_CHK;
					end else begin
						state_d = S_FIN;
					end
				end else if (sts.is_region) begin
					state_d = S_PREP;
				end else begin
					state_d = S_FIN;
				end
			end
			S_A_CHK: begin
				if (sts.word_free) begin
					cmd.alloc_wr = 1'b1;
					state_d      = S_FIN;
				end else if (sts.scan_last) begin
					state_d = S_FIN;
				end else begin
					cmd.rd_nxt = 1'b1;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = sts.rgn_nonempty ? S_R_RD : S_Z_RD;
			end
			S_R_RD: begin
				cmd.rd_cur = 1'b1;
				state_d    = S_R_WR;
			end
			S_R_WR: begin
				cmd.rgn_wr = 1'b1;
				// next word is read while this one is written
				if (sts.rgn_last) state_d = S_Z_RD;
				else cmd.rd_nxt = 1'b1;
			end
			S_Z_RD: begin
				cmd.rd_zero = 1'b1;
				state_d     = S_Z_WR;
			end
			S_Z_WR: begin
				cmd.zero_wr = 1'b1;
				state_d     = S_FIN;
			end
			S_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.rsp_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (cfg_wr_en) begin
			cmd           = '0;
			cmd.fill_init = 1'b1;
			state_d       = S_FILL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

endmodule

// File: hdl/bfa_datapath.sv
module bfa_datapath #(
	parameter int NUM_FRAMES  = bfa_pkg::NUM_FRAMES_DEF,
	parameter int FRAME_BYTES = bfa_pkg::FRAME_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [bfa_pkg::CNT_W-1:0]    cfg_wr_data,
	input  bfa_pkg::bfa_cmd_t            cmd,
	output bfa_pkg::bfa_sts_t            sts,
	input  logic [bfa_pkg::REQ_W-1:0]    req_type,
	input  logic [bfa_pkg::BASE_W-1:0]   region_base,
	input  logic [bfa_pkg::BASE_W-1:0]   region_size,
	output logic [bfa_pkg::ADDR_W-1:0]   frame_address,
	output logic                         success,
	output logic [bfa_pkg::CNT_W-1:0]    frames_in_use
);

	localparam int CW   = bfa_pkg::CNT_W;
	localparam int AW   = bfa_pkg::ADDR_W;
	localparam int FS   = $clog2(FRAME_BYTES);
	localparam int BW   = (NUM_FRAMES + 31) / 32;
	localparam int WW   = (BW > 1) ? $clog2(BW) : 1;
	localparam int AWRD = NUM_FRAMES / 32;
	localparam int NFW  = $clog2(NUM_FRAMES + 1);
	localparam int EW   = ((33 - FS) > NFW) ? (33 - FS) : NFW;
	localparam int LW   = (11 > $clog2(AWRD + 1)) ? 11 : $clog2(AWRD + 1);
	localparam int KW   = (NFW > CW) ? NFW : CW;
	localparam int HW   = WW + 5 + FS;

	logic [31:0]           bm_mem [BW];
	logic [31:0]           rd_data_q;
	logic                  mem_we;
	logic [WW-1:0]         wr_addr;
	logic [31:0]           wr_data;
	logic                  mem_re;
	logic [WW-1:0]         rd_addr;

	logic [CW-1:0]         total_q, used_q;
	logic [WW-1:0]         wp_q;
	logic [bfa_pkg::REQ_W-1:0] req_q;
	logic [EW-1:0]         first_q, end_q;
	logic [NFW-1:0]        n_q;
	logic [WW-1:0]         wfirst_q, wlast_q;
	logic [4:0]            lo_q, hi_q;
	logic [AW-1:0]         addr_q;
	logic                  ok_q;
	logic [AW-1:0]         rsp_addr_q;
	logic                  rsp_ok_q;
	logic [CW-1:0]         rsp_cnt_q;

	// allocation scan
	logic [LW-1:0]         lim_tot, lim;
	logic [31:0]           low0;
	logic [4:0]            hit_idx;
	logic [HW-1:0]         hit_byte;

	// region bounds
	logic [EW-1:0]         endc, span, lastf;
	logic                  nonempty;
	logic [4:0]            lo, hi;
	logic [31:0]           mask, rgn_word;

	// count update
	logic [KW-1:0]         n_k, u_k;
	logic [KW:0]           sum_k;
	logic [CW-1:0]         cnt_rel, cnt_res, cnt_rgn;

	assign lim_tot = LW'(total_q >> 5);
	assign lim     = (lim_tot > LW'(AWRD)) ? LW'(AWRD) : lim_tot;

	// one-hot of the lowest clear bit
	assign low0 = ~rd_data_q & (rd_data_q + 32'd1);

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < 32; i++) begin
			if (low0[i]) hit_idx = hit_idx | 5'(i);
		end
	end

	assign hit_byte = {wp_q, hit_idx, {FS{1'b0}}};

	assign endc     = (end_q > EW'(NUM_FRAMES)) ? EW'(NUM_FRAMES) : end_q;
	assign nonempty = endc > first_q;
	assign span     = endc - first_q;
	assign lastf    = endc - EW'(1);

	assign lo   = (wp_q == wfirst_q) ? lo_q : 5'd0;
	assign hi   = (wp_q == wlast_q) ? hi_q : 5'd31;
	assign mask = ({32{1'b1}} << lo) & ({32{1'b1}} >> (5'd31 - hi));
	assign rgn_word = (req_q == bfa_pkg::REQ_RESERVE) ? (rd_data_q | mask)
		: (rd_data_q & ~mask);

	assign n_k     = KW'(n_q);
	assign u_k     = KW'(used_q);
	assign sum_k   = (KW+1)'(used_q) + (KW+1)'(n_q);
	assign cnt_rel = (n_k >= u_k) ? '0 : CW'(u_k - n_k);
	assign cnt_res = (sum_k > (KW+1)'(total_q)) ? total_q : CW'(sum_k);
	assign cnt_rgn = (req_q == bfa_pkg::REQ_RESERVE) ? cnt_res : cnt_rel;

	always_comb begin
		sts.fill_last    = (wp_q == WW'(BW - 1));
		sts.is_alloc     = (req_q == bfa_pkg::REQ_ALLOC);
		sts.is_region    = (req_q == bfa_pkg::REQ_RELEASE) || (req_q == bfa_pkg::REQ_RESERVE);
		sts.alloc_go     = (used_q < total_q) && (lim != '0);
		sts.word_free    = (rd_data_q != 32'hFFFF_FFFF);
		sts.scan_last    = ((LW'(wp_q) + LW'(1)) >= lim);
		sts.rgn_nonempty = nonempty;
		sts.rgn_last     = (wp_q == wlast_q);
	end

	// bitmap memory port muxing
	always_comb begin
		mem_we  = 1'b0;
		wr_addr = wp_q;
		wr_data = rd_data_q;
		if (cmd.fill_wr) begin
			mem_we  = 1'b1;
			wr_data = 32'hFFFF_FFFF;
		end else if (cmd.alloc_wr) begin
			mem_we  = 1'b1;
			wr_data = rd_data_q | low0;
		end else if (cmd.rgn_wr) begin
			mem_we  = 1'b1;
			wr_data = rgn_word;
		end else if (cmd.zero_wr) begin
			mem_we  = 1'b1;
			wr_addr = '0;
			wr_data = rd_data_q | 32'd1;
		end
		mem_re = cmd.rd_cur || cmd.rd_nxt || cmd.rd_zero;
		if (cmd.rd_zero) rd_addr = '0;
		else if (cmd.rd_nxt) rd_addr = WW'(wp_q + 1'b1);
		else rd_addr = wp_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) bm_mem[wr_addr] <= wr_data;
		if (mem_re) rd_data_q <= bm_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= bfa_pkg::TOTAL_RST;
			used_q  <= bfa_pkg::TOTAL_RST;
			wp_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				total_q <= cfg_wr_data;
				used_q  <= cfg_wr_data;
			end else if (cmd.alloc_wr) begin
				used_q <= used_q + 1'b1;
			end else if (cmd.zero_wr) begin
				used_q <= cnt_rgn;
			end

			if (cmd.fill_init || cmd.load) wp_q <= '0;
			else if (cmd.fill_wr || cmd.rd_nxt) wp_q <= WW'(wp_q + 1'b1);
			else if (cmd.prep) wp_q <= WW'(first_q >> 5);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			first_q <= EW'(region_base >> FS);
			end_q   <= EW'(region_base >> FS) + EW'(region_size >> FS);
			addr_q  <= '0;
			ok_q    <= 1'b0;
		end else begin
			if (cmd.alloc_wr) begin
				addr_q <= AW'(hit_byte);
				ok_q   <= 1'b1;
			end
			if (cmd.zero_wr) ok_q <= 1'b1;
		end
		if (cmd.prep) begin
			n_q      <= nonempty ? NFW'(span) : '0;
			wfirst_q <= WW'(first_q >> 5);
			wlast_q  <= WW'(lastf >> 5);
			lo_q     <= first_q[4:0];
			hi_q     <= lastf[4:0];
		end
		if (cmd.rsp_load) begin
			rsp_addr_q <= addr_q;
			rsp_ok_q   <= ok_q;
			rsp_cnt_q  <= used_q;
		end
	end

	assign frame_address = rsp_addr_q;
	assign success       = rsp_ok_q;
	assign frames_in_use = rsp_cnt_q;

endmodule

// File: verif/bitmap_frame_allocator_test.sv
`timescale 1ns / 100ps

module bitmap_frame_allocator_test;

	localparam int MAP_WORDS = bfa_pkg::NUM_FRAMES_DEF / 32;
	localparam logic [bfa_pkg::REQ_W-1:0] REQ_UNDEF = 2'd3;
	localparam int SHOWN_MAX = 10;

	typedef struct packed {
		logic [bfa_pkg::ADDR_W-1:0] frame_address;
		logic                       success;
		logic [bfa_pkg::CNT_W-1:0]  frames_in_use;
	} alloc_reply_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wr_en;
	logic [bfa_pkg::CNT_W-1:0] cfg_wr_data;

	bfa_req_if req_if();
	bfa_rsp_if rsp_if();

	bitmap_frame_allocator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_if),
		.rsp         (rsp_if)
	);

	// shadow of the allocator state
	logic [31:0]               frame_map [MAP_WORDS];
	logic [bfa_pkg::CNT_W-1:0] frames_used;
	logic [bfa_pkg::CNT_W-1:0] frames_total;

	alloc_reply_t awaited_replies[$];
	int           faults = 0;
	int           rsp_hold = 0;
	bit           idle_on;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#48_000_000;
		$display("bitmap_frame_allocator_test: done, errors");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] frames_to_bytes(int n);
		return 32'(n * bfa_pkg::FRAME_BYTES_DEF);
	endfunction

	function automatic void wipe_map(logic [bfa_pkg::CNT_W-1:0] total);
		foreach (frame_map[w])
			frame_map[w] = '1;
		frames_total = total;
		frames_used  = total;
	endfunction

	function automatic alloc_reply_t predict_request(logic [bfa_pkg::REQ_W-1:0] kind,
		logic [31:0] base, logic [31:0] size);
		alloc_reply_t reply;
		logic [63:0]  first_f, end_f, span, sum;
		logic [63:0]  mask;
		int           scan_words, w, b, first_w, last_w, lo, hi;
		reply = '0;
		if (kind == bfa_pkg::REQ_ALLOC) begin
			if (frames_used < frames_total) begin
				scan_words = frames_total / 32;
				if (scan_words > MAP_WORDS)
					scan_words = MAP_WORDS;
				for (w = 0; w < scan_words && !reply.success; w++) begin
					if (frame_map[w] != '1) begin
						for (b = 0; b < 32; b++)
							if (!frame_map[w][b])
								break;
						frame_map[w][b] = 1'b1;
						frames_used++;
						reply.frame_address =
							bfa_pkg::ADDR_W'((w * 32 + b) * bfa_pkg::FRAME_BYTES_DEF);
						reply.success = 1'b1;
					end
				end
			end
		end else if (kind == bfa_pkg::REQ_RELEASE || kind == bfa_pkg::REQ_RESERVE) begin
			first_f = {32'd0, base} / 64'(bfa_pkg::FRAME_BYTES_DEF);
			end_f = first_f + {32'd0, size} / 64'(bfa_pkg::FRAME_BYTES_DEF);
			if (end_f > 64'(bfa_pkg::NUM_FRAMES_DEF))
				end_f = 64'(bfa_pkg::NUM_FRAMES_DEF);
			span = (end_f > first_f) ? end_f - first_f : 64'd0;
			if (span != 0) begin
				first_w = int'(first_f >> 5);
				last_w  = int'((end_f - 1) >> 5);
				for (w = first_w; w <= last_w; w++) begin
					lo = (w == first_w) ? int'(first_f % 32) : 0;
					hi = (w == last_w) ? int'((end_f - 1) % 32) : 31;
					mask = ((64'd2 << hi) - 1) & ~((64'd1 << lo) - 1);
					if (kind == bfa_pkg::REQ_RESERVE)
						frame_map[w] = frame_map[w] | mask[31:0];
					else
						frame_map[w] = frame_map[w] & ~mask[31:0];
				end
			end
			// count moves by the frame span, not by bits that actually changed
			if (kind == bfa_pkg::REQ_RELEASE) begin
				frames_used = (span >= frames_used) ? '0
					: frames_used - span[bfa_pkg::CNT_W-1:0];
			end else begin
				sum = span + frames_used;
				if (sum > frames_total)
					sum = frames_total;
				frames_used = sum[bfa_pkg::CNT_W-1:0];
			end
			frame_map[0][0] = 1'b1;
			reply.success = 1'b1;
		end
		reply.frames_in_use = frames_used;
		return reply;
	endfunction

	task automatic send_request(logic [bfa_pkg::REQ_W-1:0] kind, logic [31:0] base,
		logic [31:0] size);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.req_type    <= kind;
		req_if.region_base <= base;
		req_if.region_size <= size;
		do @(posedge clk); while (!req_if.ready);
		awaited_replies.push_back(predict_request(kind, base, size));
	endtask

	task automatic wait_all_replies();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_total(logic [bfa_pkg::CNT_W-1:0] total);
		wait_all_replies();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= total;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		wipe_map(total);
	endtask

	// response side: check against the oldest prediction, then draw a stall
	always @(posedge clk) begin
		alloc_reply_t seen, want;
		if (rsp_if.valid && rsp_if.ready) begin
			seen = '{rsp_if.frame_address, rsp_if.success, rsp_if.frames_in_use};
			if (awaited_replies.size() == 0) begin
				if (faults < SHOWN_MAX)
					$display("%0t: unexpected response addr=%h ok=%b used=%0d", $realtime,
						seen.frame_address, seen.success, seen.frames_in_use);
				faults++;
			end else begin
				want = awaited_replies.pop_front();
				if (seen.frame_address !== want.frame_address || seen.success !== want.success ||
					seen.frames_in_use !== want.frames_in_use) begin
					if (faults < SHOWN_MAX)
						$display("%0t: mismatch exp addr=%h ok=%b used=%0d, got addr=%h ok=%b used=%0d",
							$realtime, want.frame_address, want.success, want.frames_in_use,
							seen.frame_address, seen.success, seen.frames_in_use);
					faults++;
				end
			end
			rsp_hold = pick_gap();
		end
		if (rsp_hold > 0) begin
			rsp_if.ready <= 1'b0;
			rsp_hold--;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	task automatic test_after_reset();
		send_request(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
		send_request(REQ_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(bfa_pkg::REQ_RESERVE, 32'd0, 32'h0000_0FFF);
		// first frame far past the bitmap
		send_request(bfa_pkg::REQ_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_region_edges();
		send_request(bfa_pkg::REQ_RELEASE, frames_to_bytes(1) | 32'hABC, frames_to_bytes(3));
		repeat (4) send_request(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
		// frame 0 comes back used: count drops but the map stays full
		send_request(bfa_pkg::REQ_RELEASE, 32'd0, frames_to_bytes(1));
		send_request(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
		send_request(bfa_pkg::REQ_RELEASE, 32'd0, 32'hFFFF_FFFF);
		send_request(bfa_pkg::REQ_RELEASE, 32'd0, 32'hFFFF_FFFF);
		send_request(bfa_pkg::REQ_ALLOC, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
		send_request(bfa_pkg::REQ_RESERVE, 32'd0, 32'hFFFF_FFFF);
		send_request(bfa_pkg::REQ_RELEASE, frames_to_bytes(bfa_pkg::NUM_FRAMES_DEF - 1),
			32'hFFFF_FFFF);
		send_request(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
		send_request(bfa_pkg::REQ_RESERVE, frames_to_bytes(bfa_pkg::NUM_FRAMES_DEF - 40),
			frames_to_bytes(80));
		send_request(REQ_UNDEF, 32'd0, 32'd0);
	endtask

	task automatic test_config_extremes();
		write_total(16'd0);
		send_request(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
		send_request(bfa_pkg::REQ_RELEASE, frames_to_bytes(4), frames_to_bytes(8));
		send_request(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
		send_request(bfa_pkg::REQ_RESERVE, 32'd0, frames_to_bytes(2));
		// less than one full word: nothing can be scanned
		write_total(16'd31);
		send_request(bfa_pkg::REQ_RELEASE, 32'd0, frames_to_bytes(64));
		send_request(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
		write_total(16'd33);
		send_request(bfa_pkg::REQ_RELEASE, frames_to_bytes(2), frames_to_bytes(40));
		repeat (2) send_request(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
		// free frames only in the partial top word
		write_total(16'd32767);
		send_request(bfa_pkg::REQ_RELEASE, frames_to_bytes(32760), frames_to_bytes(8));
		send_request(bfa_pkg::REQ_ALLOC, 32'd0, 32'd0);
	endtask

	task automatic send_random_request(int total);
		int                         r, span_hi, first, nfr;
		logic [bfa_pkg::REQ_W-1:0]  kind;
		logic [31:0]                base, size;
		r = $urandom_range(0, 99);
		kind = (r < 45) ? bfa_pkg::REQ_ALLOC : (r < 75) ? bfa_pkg::REQ_RELEASE :
			(r < 97) ? bfa_pkg::REQ_RESERVE : REQ_UNDEF;
		// keep most regions low so allocation scans stay short
		span_hi = (total > 2048) ? 2048 : total + 32;
		r = $urandom_range(0, 99);
		first = (r < 88) ? $urandom_range(0, span_hi) :
			$urandom_range(0, bfa_pkg::NUM_FRAMES_DEF + 64);
		base = frames_to_bytes(first) | $urandom_range(0, bfa_pkg::FRAME_BYTES_DEF - 1);
		r = $urandom_range(0, 99);
		nfr = (r < 90) ? $urandom_range(0, 40) :
			(r < 97) ? $urandom_range(41, 2000) : $urandom_range(2001, bfa_pkg::NUM_FRAMES_DEF);
		size = frames_to_bytes(nfr) | $urandom_range(0, bfa_pkg::FRAME_BYTES_DEF - 1);
		if ($urandom_range(0, 49) == 0)
			base = $urandom();
		if ($urandom_range(0, 49) == 0)
			size = $urandom();
		send_request(kind, base, size);
	endtask

	task automatic test_random_traffic(int n_reqs, int total, bit with_idle);
		write_total(bfa_pkg::CNT_W'(total));
		idle_on = with_idle;
		for (int i = 0; i < n_reqs; i++) begin
			if (i == n_reqs / 2 && $urandom_range(0, 1) == 1)
				wait_all_replies();
			send_random_request(total);
		end
		idle_on = 1'b1;
	endtask

	initial begin
		req_if.valid       <= 1'b0;
		req_if.req_type    <= bfa_pkg::REQ_ALLOC;
		req_if.region_base <= '0;
		req_if.region_size <= '0;
		cfg_wr_en          <= 1'b0;
		cfg_wr_data        <= '0;
		arst_n             <= 1'b0;
		idle_on  = 1'b0;
		wipe_map(bfa_pkg::TOTAL_RST);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_after_reset();
		idle_on = 1'b1;
		test_region_edges();
		test_config_extremes();
		test_random_traffic(150, 32768, 1'b0);
		test_random_traffic(130, $urandom_range(1024, 32768), 1'b1);
		test_random_traffic(110, 1000, 1'b1);
		test_random_traffic(130, 32768, 1'b1);
		test_random_traffic(120, $urandom_range(32, 32768), 1'b0);
		test_random_traffic(60, 64, 1'b1);

		wait_all_replies();
		repeat (40) @(posedge clk);
		if (faults == 0 && awaited_replies.size() == 0)
			$display("bitmap_frame_allocator_test: done, clean");
		else
			$display("bitmap_frame_allocator_test: done, errors");
		$finish;
	end

endmodule

// File: files.f
hdl/bfa_pkg.sv
hdl/bfa_req_if.sv
hdl/bfa_rsp_if.sv
hdl/bfa_ctrl.sv
hdl/bfa_datapath.sv
hdl/bitmap_frame_allocator.sv
verif/bitmap_frame_allocator_test.sv
